// ===== sv/ckr_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock RAM register window package
// Shared widths, register addresses, clock byte indices and a helper function.
// ----------------------------------------------------------------------------
package ckr_pkg;

   localparam int unsigned ADDR_W = 6;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned FLAG_W = 3;

   localparam int unsigned CLOCK_BYTES_DEFAULT = 80;
   localparam int unsigned IO_REGS_DEFAULT     = 64;

   localparam logic [ADDR_W-1:0] REG_CLKRD = 6'h3B;
   localparam logic [ADDR_W-1:0] REG_CTRL  = 6'h3D;
   localparam logic [ADDR_W-1:0] REG_INDEX = 6'h3E;
   localparam logic [ADDR_W-1:0] REG_DATA  = 6'h3F;

   localparam logic [DATA_W-1:0] IDX_FLAGS     = 8'h0A;
   localparam logic [DATA_W-1:0] IDX_ALARM     = 8'h0B;
   localparam logic [DATA_W-1:0] IDX_PROTECTED = 8'h07;
   localparam logic [DATA_W-1:0] IDX_CLKRD     = 8'h3B;

   localparam logic [DATA_W-1:0] CTRL_ALARM_VALUE = 8'hF8;
   localparam logic [DATA_W-1:0] CLKRD_MASK       = 8'hFE;
   localparam logic [1:0]        CTRL_CLKRD_OFF   = 2'b00;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   // Reduces a clock index modulo the clock RAM size; the caller must keep it at
   // least 64, unchecked; four compare-and-subtract steps cover any 8-bit index.
   function automatic logic [DATA_W-1:0] clock_mod(input logic [DATA_W-1:0] idx,
                                                   input int unsigned       bytes);
      logic [DATA_W:0] v;
      logic [DATA_W:0] b;
      v = {1'b0, idx};
      b = (DATA_W+1)'(bytes);
      for (int i = 0; i < 4; i++) begin
         if (v >= b) begin
            v = v - b;
         end
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

// ===== sv/ckr_if.sv =====
// ----------------------------------------------------------------------------
// Clock RAM register window channels
// Valid/ready interfaces for bus accesses and their results.
// ----------------------------------------------------------------------------
interface ckr_req_if import ckr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] wdata;

   modport source (output valid, output op, output addr, output wdata, input ready);
   modport sink   (input valid, input op, input addr, input wdata, output ready);
endinterface

interface ckr_rsp_if import ckr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] rdata;
   logic [FLAG_W-1:0] alarm_flags;

   modport source (output valid, output rdata, output alarm_flags, input ready);
   modport sink   (input valid, input rdata, input alarm_flags, output ready);
endinterface

// ===== sv/ckr_ram.sv =====
// ----------------------------------------------------------------------------
// Clock RAM register window generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ckr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/clock_ram_register_window.sv =====
// ----------------------------------------------------------------------------
// Clock RAM register window
// I/O register window with an indexed data port into a battery clock RAM.
// ----------------------------------------------------------------------------
// Each transfer on req_chan is one bus access: op selects read or write, addr
// names one of the I/O registers and wdata carries the byte of a write.
// Register 0x3E holds the clock index and register 0x3F is the data port.
// Every access produces exactly one transfer on rsp_chan with the byte read
// (zero for writes) and the sticky alarm flags after the access.
// Writes take effect in the cycle the request is accepted; reads go through
// the registered read ports of the I/O RAM and the clock RAM.
// The read data registers of the RAMs and the response register lie between a
// request and its response, and only one access is in flight: no new request
// is taken while the block is in its read state.
// Reset clears the flags and the valid bits of both RAMs at once, so every
// byte reads as zero until it is written; no clearing pass is needed.
// A stalled response stays in the output register; a new request is taken
// only once that response has been transferred or is transferring.
// ----------------------------------------------------------------------------
module clock_ram_register_window import ckr_pkg::*; #(
   parameter int unsigned CLOCK_BYTES = CLOCK_BYTES_DEFAULT,
   parameter int unsigned IO_REGS     = IO_REGS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   ckr_req_if.sink   req_chan,
   ckr_rsp_if.source rsp_chan
);

   localparam int unsigned CLK_AW = $clog2(CLOCK_BYTES);
   localparam int unsigned IO_AW  = $clog2(IO_REGS);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef enum logic [2:0] {
      RD_WRITE,
      RD_DATA,
      RD_CLKRD,
      RD_SHADOW,
      RD_PLAIN
   } kind_type;

   state_type         state_ff;
   kind_type          kind_ff, kind_in;
   logic [DATA_W-1:0] ctrl_ff, ctrl_in;
   logic [DATA_W-1:0] index_ff, index_in;
   logic              alarm_ff, alarm_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic [DATA_W-1:0] hold_ff, hold_in;
   logic              in_range_ff, in_range_in;
   logic              is_alarm_ff, is_alarm_in;
   logic              io_bit_ff, clk_bit_ff;
   logic              io_vld_ff [IO_REGS];
   logic              clk_vld_ff [CLOCK_BYTES];
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic [FLAG_W-1:0] rsp_flags_ff;

   logic              accept;
   logic              io_we, clk_we;
   logic [IO_AW-1:0]  io_waddr, io_raddr;
   logic [CLK_AW-1:0] clk_waddr, clk_raddr;
   logic [DATA_W-1:0] clk_wdata;
   logic [DATA_W-1:0] io_rdata, clk_rdata;
   logic [DATA_W-1:0] idx_mod;
   logic [DATA_W-1:0] clk_byte;

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign idx_mod        = clock_mod(index_ff, CLOCK_BYTES);

   always_comb begin
      io_we       = 1'b0;
      io_waddr    = IO_AW'(req_chan.addr);
      io_raddr    = IO_AW'(req_chan.addr);
      clk_we      = 1'b0;
      clk_waddr   = idx_mod[CLK_AW-1:0];
      clk_wdata   = req_chan.wdata;
      clk_raddr   = index_ff[CLK_AW-1:0];
      ctrl_in     = ctrl_ff;
      index_in    = index_ff;
      alarm_in    = alarm_ff;
      flags_in    = flags_ff;
      kind_in     = kind_ff;
      hold_in     = hold_ff;
      in_range_in = in_range_ff;
      is_alarm_in = is_alarm_ff;
      if (accept) begin
         if (op_type'(req_chan.op) == OP_WRITE) begin
            kind_in = RD_WRITE;
            io_we   = 1'b1;
            if (req_chan.addr == REG_CTRL) begin
               ctrl_in = req_chan.wdata;
            end
            if (req_chan.addr == REG_INDEX) begin
               index_in = req_chan.wdata;
            end
            if (req_chan.addr == REG_DATA) begin
               priority if (index_ff == IDX_ALARM) begin
                  ctrl_in  = CTRL_ALARM_VALUE;
                  flags_in = flags_ff | req_chan.wdata[FLAG_W-1:0];
                  alarm_in = req_chan.wdata[DATA_W-1];
               end else if (index_ff == IDX_FLAGS) begin
                  flags_in  = flags_ff | req_chan.wdata[FLAG_W-1:0];
                  clk_we    = 1'b1;
                  clk_waddr = IDX_FLAGS[CLK_AW-1:0];
               end else if (index_ff >= IDX_PROTECTED) begin
                  clk_we = 1'b1;
                  if (idx_mod == IDX_ALARM) begin
                     alarm_in = req_chan.wdata[DATA_W-1];
                  end
               end else begin
                  clk_we    = !alarm_ff;
                  clk_waddr = index_ff[CLK_AW-1:0];
               end
            end
         end else begin
            priority if (req_chan.addr == REG_DATA) begin
               kind_in     = RD_DATA;
               clk_raddr   = index_ff[CLK_AW-1:0];
               in_range_in = (index_ff < DATA_W'(CLOCK_BYTES));
               is_alarm_in = (index_ff == IDX_ALARM);
            end else if (req_chan.addr == REG_CLKRD && ctrl_ff[1:0] == CTRL_CLKRD_OFF) begin
               kind_in     = RD_CLKRD;
               clk_raddr   = IDX_CLKRD[CLK_AW-1:0];
               is_alarm_in = 1'b0;
            end else if (req_chan.addr == REG_CTRL) begin
               kind_in = RD_SHADOW;
               hold_in = ctrl_ff;
            end else if (req_chan.addr == REG_INDEX) begin
               kind_in = RD_SHADOW;
               hold_in = index_ff;
            end else begin
               kind_in = RD_PLAIN;
            end
         end
      end
   end

   ckr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (IO_REGS)
   ) u_io_ram (
      .clock (clock),
      .we    (io_we),
      .waddr (io_waddr),
      .wdata (req_chan.wdata),
      .raddr (io_raddr),
      .rdata (io_rdata)
   );

   ckr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CLOCK_BYTES)
   ) u_clock_ram (
      .clock (clock),
      .we    (clk_we),
      .waddr (clk_waddr),
      .wdata (clk_wdata),
      .raddr (clk_raddr),
      .rdata (clk_rdata)
   );

   always_comb begin
      clk_byte = clk_bit_ff ? clk_rdata : '0;
      if (is_alarm_ff) begin
         clk_byte[DATA_W-1] = alarm_ff;
      end
      unique case (kind_ff)
         RD_WRITE:  rdata_in = '0;
         RD_DATA:   rdata_in = in_range_ff ? clk_byte : '0;
         RD_CLKRD:  rdata_in = clk_byte & CLKRD_MASK;
         RD_SHADOW: rdata_in = hold_ff;
         RD_PLAIN:  rdata_in = io_bit_ff ? io_rdata : '0;
         default:   rdata_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      hold_ff     <= hold_in;
      in_range_ff <= in_range_in;
      is_alarm_ff <= is_alarm_in;
      io_bit_ff   <= io_vld_ff[io_raddr];
      clk_bit_ff  <= clk_vld_ff[clk_raddr];
      if (state_ff == ST_READ) begin
         rdata_ff     <= rdata_in;
         rsp_flags_ff <= flags_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         index_ff     <= '0;
         alarm_ff     <= 1'b0;
         flags_ff     <= '0;
         for (int i = 0; i < IO_REGS; i++) begin
            io_vld_ff[i] <= 1'b0;
         end
         for (int i = 0; i < CLOCK_BYTES; i++) begin
            clk_vld_ff[i] <= 1'b0;
         end
      end else begin
         ctrl_ff  <= ctrl_in;
         index_ff <= index_in;
         alarm_ff <= alarm_in;
         flags_ff <= flags_in;
         if (io_we) begin
            io_vld_ff[io_waddr] <= 1'b1;
         end
         if (clk_we) begin
            clk_vld_ff[clk_waddr] <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_valid_ff && rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.rdata       = rdata_ff;
   assign rsp_chan.alarm_flags = rsp_flags_ff;

   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid_ff)
      else $error("Accepted access did not produce a response.");

   a_no_accept_while_reading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !req_chan.ready)
      else $error("Request taken while a read was in flight.");

   a_flags_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((flags_ff & $past(flags_ff)) == $past(flags_ff)))
      else $error("Sticky alarm flag was lost.");

   a_alarm_write_sets_ctrl: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.op == OP_WRITE && req_chan.addr == REG_DATA
       && index_ff == IDX_ALARM) |=> (ctrl_ff == CTRL_ALARM_VALUE))
      else $error("Alarm index write did not set the control register.");

endmodule

// ===== tb/tb_clock_ram_register_window.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clock RAM register window testbench
// Runs directed and random bus accesses into the block under random bursts,
// gaps and response stalls. A scoreboard keeps shadow copies of the I/O
// registers, the clock RAM and the alarm flags, predicts each response in
// order and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_clock_ram_register_window import ckr_pkg::*; ();

   localparam int unsigned CLOCK_SIZE = CLOCK_BYTES_DEFAULT;
   localparam int unsigned REG_COUNT  = IO_REGS_DEFAULT;
   localparam int          RANDOM_ACCESSES = 700;
   localparam int          HOLD_AFTER_RESULTS = 300;
   localparam int          HOLD_CYCLES = 60;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } bus_access_type;

   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      logic [FLAG_W-1:0] flags;
   } window_result_type;

   typedef enum int {
      SINK_STEADY,
      SINK_RANDOM,
      SINK_PERIODIC
   } sink_mode_type;

   class clock_window_scoreboard;
      logic [DATA_W-1:0] io_shadow [REG_COUNT];
      logic [DATA_W-1:0] clock_shadow [CLOCK_SIZE];
      logic [FLAG_W-1:0] flag_shadow;
      window_result_type expected_results [$];
      int                error_count;
      int                accesses_noted;
      int                results_checked;
      int                port_writes;
      int                blocked_writes;

      function new();
         foreach (io_shadow[i]) io_shadow[i] = '0;
         foreach (clock_shadow[i]) clock_shadow[i] = '0;
         flag_shadow = '0;
         error_count = 0;
         accesses_noted = 0;
         results_checked = 0;
         port_writes = 0;
         blocked_writes = 0;
      endfunction

      function void note_access(bus_access_type acc);
         window_result_type res;
         logic [DATA_W-1:0] idx;
         res.rdata = '0;
         idx = io_shadow[REG_INDEX];
         accesses_noted++;
         if (acc.op == OP_WRITE) begin
            if (acc.addr == REG_DATA) begin
               port_writes++;
               io_shadow[REG_DATA] = acc.wdata;
               if (idx == IDX_ALARM) begin
                  io_shadow[REG_CTRL] = CTRL_ALARM_VALUE;
                  flag_shadow = flag_shadow | acc.wdata[FLAG_W-1:0];
                  clock_shadow[IDX_ALARM][7] = acc.wdata[7];
               end else if (idx == IDX_FLAGS) begin
                  flag_shadow = flag_shadow | acc.wdata[FLAG_W-1:0];
                  clock_shadow[IDX_FLAGS] = acc.wdata;
               end else if (idx >= IDX_PROTECTED) begin
                  clock_shadow[int'(idx) % CLOCK_SIZE] = acc.wdata;
               end else if (!clock_shadow[IDX_ALARM][7]) begin
                  clock_shadow[idx] = acc.wdata;
               end else begin
                  blocked_writes++;
               end
            end else begin
               io_shadow[acc.addr] = acc.wdata;
            end
         end else if (acc.addr == REG_DATA) begin
            res.rdata = (idx < CLOCK_SIZE) ? clock_shadow[idx] : '0;
         end else if (acc.addr == REG_CLKRD && io_shadow[REG_CTRL][1:0] == CTRL_CLKRD_OFF) begin
            res.rdata = clock_shadow[IDX_CLKRD] & CLKRD_MASK;
         end else begin
            res.rdata = io_shadow[acc.addr];
         end
         res.flags = flag_shadow;
         expected_results = {expected_results, res};
      endfunction

      function void check_result(logic [DATA_W-1:0] rdata, logic [FLAG_W-1:0] flags);
         window_result_type exp_res;
         results_checked++;
         if (expected_results.size() == 0) begin
            $display("%0t: response with none expected, rdata %02h, alarm_flags %0d",
                     $time, rdata, flags);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rdata !== exp_res.rdata) begin
               $display("%0t: rdata mismatch, expected %02h, actual %02h",
                        $time, exp_res.rdata, rdata);
               error_count++;
            end
            if (flags !== exp_res.flags) begin
               $display("%0t: alarm_flags mismatch, expected %0d, actual %0d",
                        $time, exp_res.flags, flags);
               error_count++;
            end
         end
      endfunction

      function void report_missing();
         if (expected_results.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, expected_results.size());
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ckr_req_if access_if ();
   ckr_rsp_if result_if ();

   clock_window_scoreboard scoreboard = new();
   bus_access_type         access_plan [$];
   bit                     rsp_hold_active = 1'b0;

   clock_ram_register_window i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (access_if),
      .rsp_chan (result_if)
   );

   always #6 clock = ~clock;

   task automatic plan_access(op_type op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
      bus_access_type acc;
      acc.op = op;
      acc.addr = addr;
      acc.wdata = wdata;
      access_plan = {access_plan, acc};
   endtask

   function automatic logic [DATA_W-1:0] pick_clock_index();
      unique case ($urandom_range(0, 6))
         0: return IDX_ALARM;
         1: return IDX_FLAGS;
         2: return DATA_W'($urandom_range(0, 6));
         3: return DATA_W'($urandom_range(80, 255));
         4: return IDX_CLKRD;
         default: return DATA_W'($urandom_range(7, 79));
      endcase
   endfunction

   task automatic plan_random_accesses();
      int kind;
      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            plan_access(OP_WRITE, REG_INDEX, pick_clock_index());
         end else if (kind < 45) begin
            plan_access(OP_WRITE, REG_DATA, DATA_W'($urandom_range(0, 255)));
         end else if (kind < 65) begin
            plan_access(OP_READ, REG_DATA, DATA_W'($urandom_range(0, 255)));
         end else if (kind < 72) begin
            plan_access(OP_READ, REG_CLKRD, DATA_W'($urandom_range(0, 255)));
         end else if (kind < 77) begin
            plan_access(OP_WRITE, REG_CTRL,
                        DATA_W'($urandom_range(0, 255)) & ($urandom_range(0, 1) ? 8'hFF : 8'hFC));
         end else begin
            plan_access(op_type'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 63)),
                        DATA_W'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic plan_directed_accesses();
      plan_access(OP_READ,  REG_DATA,  8'h00);
      plan_access(OP_READ,  REG_CLKRD, 8'hFF);
      plan_access(OP_WRITE, 6'h00,     8'hFF);
      plan_access(OP_READ,  6'h00,     8'h00);
      plan_access(OP_WRITE, REG_INDEX, IDX_ALARM);
      plan_access(OP_WRITE, REG_DATA,  8'h87);
      plan_access(OP_READ,  REG_DATA,  8'h00);
      plan_access(OP_READ,  REG_CTRL,  8'h00);
      plan_access(OP_WRITE, REG_INDEX, 8'h03);
      plan_access(OP_WRITE, REG_DATA,  8'h55);
      plan_access(OP_READ,  REG_DATA,  8'h00);
      plan_access(OP_WRITE, REG_INDEX, IDX_FLAGS);
      plan_access(OP_WRITE, REG_DATA,  8'hFF);
      plan_access(OP_WRITE, REG_INDEX, 8'hFF);
      plan_access(OP_WRITE, REG_DATA,  8'hA5);
      plan_access(OP_READ,  REG_DATA,  8'h00);
      plan_access(OP_WRITE, REG_INDEX, 8'h0F);
      plan_access(OP_READ,  REG_DATA,  8'h00);
      plan_access(OP_WRITE, REG_INDEX, IDX_CLKRD);
      plan_access(OP_WRITE, REG_DATA,  8'hC3);
      plan_access(OP_READ,  REG_CLKRD, 8'h00);
      plan_access(OP_WRITE, REG_CLKRD, 8'h5A);
      plan_access(OP_WRITE, REG_CTRL,  8'h01);
      plan_access(OP_READ,  REG_CLKRD, 8'h00);
      plan_access(OP_WRITE, REG_INDEX, IDX_ALARM);
      plan_access(OP_WRITE, REG_DATA,  8'h00);
      plan_access(OP_WRITE, REG_INDEX, 8'h02);
      plan_access(OP_WRITE, REG_DATA,  8'h66);
      plan_access(OP_READ,  REG_DATA,  8'h00);
   endtask

   task automatic drive_accesses();
      int             burst_left;
      int             gap;
      bus_access_type acc;
      burst_left = 0;
      while (access_plan.size() > 0) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = rsp_hold_active ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
               access_if.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         acc = access_plan.pop_front();
         access_if.valid <= 1'b1;
         access_if.op    <= acc.op;
         access_if.addr  <= acc.addr;
         access_if.wdata <= acc.wdata;
         do @(posedge clock); while (!access_if.ready);
         scoreboard.note_access(acc);
         burst_left--;
      end
      access_if.valid <= 1'b0;
   endtask

   initial begin : result_sink
      sink_mode_type sink_mode;
      int            cycles_left_in_mode;
      int            hold_left;
      bit            hold_done;
      sink_mode = SINK_STEADY;
      cycles_left_in_mode = 0;
      hold_left = 0;
      hold_done = 1'b0;
      result_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && result_if.valid && result_if.ready) begin
            scoreboard.check_result(result_if.rdata, result_if.alarm_flags);
         end
         if (!hold_done && scoreboard.results_checked >= HOLD_AFTER_RESULTS) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_hold_active = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) begin
               rsp_hold_active = 1'b0;
            end
            result_if.ready <= 1'b0;
         end else begin
            if (cycles_left_in_mode == 0) begin
               sink_mode = sink_mode_type'($urandom_range(0, 2));
               cycles_left_in_mode = $urandom_range(16, 80);
            end
            cycles_left_in_mode--;
            unique case (sink_mode)
               SINK_STEADY: begin
                  result_if.ready <= 1'b1;
               end
               SINK_RANDOM: begin
                  result_if.ready <= ($urandom_range(0, 2) != 0);
               end
               default: begin
                  result_if.ready <= (cycles_left_in_mode % 4 != 0);
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      int drain_cycles;
      reset           <= 1'b1;
      access_if.valid <= 1'b0;
      access_if.op    <= OP_READ;
      access_if.addr  <= '0;
      access_if.wdata <= '0;
      plan_directed_accesses();
      plan_random_accesses();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      drive_accesses();
      drain_cycles = 0;
      while (scoreboard.expected_results.size() > 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      scoreboard.report_missing();
      $display("Covered %0d accesses with %0d responses compared against the shadow model.",
               scoreboard.accesses_noted, scoreboard.results_checked);
      $display("Data port writes: %0d, of which %0d were held off by the alarm protect bit.",
               scoreboard.port_writes, scoreboard.blocked_writes);
      if (scoreboard.error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
